@@ rtl/quadrature_edge_decoder_counter_defines.svh @@
// ----------------------------------------------------------------------------
// Quadrature edge decoder counter: assertion macros
// Shared property forms, clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_EDGE_DECODER_COUNTER_DEFINES_SVH
`define QUADRATURE_EDGE_DECODER_COUNTER_DEFINES_SVH

// Same-cycle implication
`define QEDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define QEDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/qedc_pkg.sv @@
// ----------------------------------------------------------------------------
// Quadrature edge decoder counter package
// Payload types, register map, decoder phase codes and transition tables.
// ----------------------------------------------------------------------------
package qedc_pkg;

  typedef struct packed {
    logic        opcode;
    logic        channel;
    logic        edge_rising;
    logic [15:0] new_count;
  } evt_t;

  typedef struct packed {
    logic [15:0] count;
    logic [2:0]  phase;
    logic [1:0]  moved;
  } res_t;

  // Operations
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Movement codes
  localparam logic [1:0] MOVE_NONE = 2'd0;
  localparam logic [1:0] MOVE_INC  = 2'd1;
  localparam logic [1:0] MOVE_DEC  = 2'd2;

  // Edge codes: {edge_rising, channel}
  localparam logic [1:0] EDGE_A_FALL = 2'd0;
  localparam logic [1:0] EDGE_B_FALL = 2'd1;
  localparam logic [1:0] EDGE_A_RISE = 2'd2;
  localparam logic [1:0] EDGE_B_RISE = 2'd3;

  // Decoder phases: idle, A-leading run, B-leading run, and an unused code
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_A1    = 3'd1;
  localparam logic [2:0] PH_A2    = 3'd2;
  localparam logic [2:0] PH_A3    = 3'd3;
  localparam logic [2:0] PH_B1    = 3'd4;
  localparam logic [2:0] PH_B2    = 3'd5;
  localparam logic [2:0] PH_B3    = 3'd6;
  localparam logic [2:0] PH_SPARE = 3'd7;

  // Register map (word index)
  localparam logic [1:0] REG_STEP_SIZE   = 2'd0;
  localparam logic [1:0] REG_UPPER_LIMIT = 2'd1;
  localparam logic [1:0] REG_LOWER_LIMIT = 2'd2;

  localparam logic [7:0]  STEP_SIZE_RST   = 8'd5;
  localparam logic [15:0] UPPER_LIMIT_RST = 16'd300;
  localparam logic [15:0] LOWER_LIMIT_RST = 16'd40;
  localparam int unsigned COUNT_RST       = 120;

  function automatic logic [2:0] next_phase(logic [2:0] p, logic [1:0] e);
    logic [2:0] n;
    n = PH_IDLE;
    unique case (p) inside
      PH_IDLE, PH_SPARE: begin
        unique case (e)
          EDGE_A_FALL: n = PH_A1;
          EDGE_B_FALL: n = PH_B1;
          EDGE_A_RISE: n = PH_IDLE;
          EDGE_B_RISE: n = PH_IDLE;
        endcase
      end
      PH_A1: begin
        unique case (e)
          EDGE_A_FALL: n = PH_A1;
          EDGE_B_FALL: n = PH_A2;
          EDGE_A_RISE: n = PH_IDLE;
          EDGE_B_RISE: n = PH_A1;
        endcase
      end
      PH_A2: begin
        unique case (e)
          EDGE_A_FALL: n = PH_A2;
          EDGE_B_FALL: n = PH_A2;
          EDGE_A_RISE: n = PH_A3;
          EDGE_B_RISE: n = PH_A1;
        endcase
      end
      PH_A3: begin
        unique case (e)
          EDGE_A_FALL: n = PH_A2;
          EDGE_B_FALL: n = PH_A3;
          EDGE_A_RISE: n = PH_A3;
          EDGE_B_RISE: n = PH_IDLE;
        endcase
      end
      PH_B1: begin
        unique case (e)
          EDGE_A_FALL: n = PH_B2;
          EDGE_B_FALL: n = PH_B1;
          EDGE_A_RISE: n = PH_B1;
          EDGE_B_RISE: n = PH_IDLE;
        endcase
      end
      PH_B2: begin
        unique case (e)
          EDGE_A_FALL: n = PH_B2;
          EDGE_B_FALL: n = PH_B2;
          EDGE_A_RISE: n = PH_B1;
          EDGE_B_RISE: n = PH_B3;
        endcase
      end
      PH_B3: begin
        unique case (e)
          EDGE_A_FALL: n = PH_B2;
          EDGE_B_FALL: n = PH_B3;
          EDGE_A_RISE: n = PH_IDLE;
          EDGE_B_RISE: n = PH_B3;
        endcase
      end
    endcase
    return n;
  endfunction

  // A full detent completes on the trailing channel's rising edge
  function automatic logic [1:0] edge_move(logic [2:0] p, logic [1:0] e);
    logic [1:0] m;
    m = MOVE_NONE;
    if (p == PH_A3 && e == EDGE_B_RISE) begin
      m = MOVE_INC;
    end else if (p == PH_B3 && e == EDGE_A_RISE) begin
      m = MOVE_DEC;
    end
    return m;
  endfunction

endpackage

@@ rtl/qedc_evt_if.sv @@
// ----------------------------------------------------------------------------
// Edge event channel
// Valid/ready stream carrying one edge event or load command per transfer.
// ----------------------------------------------------------------------------
interface qedc_evt_if;
  import qedc_pkg::*;

  logic valid;
  logic ready;
  evt_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/qedc_res_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready stream carrying count, decoder phase and movement per transfer.
// ----------------------------------------------------------------------------
interface qedc_res_if;
  import qedc_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/quadrature_edge_decoder_counter.sv @@
// Path: an event transfer is captured in the event register, and its result is
// then captured in the result register and presented on res_o.
// Throughput: one event per cycle; the event register and the result register
// advance together, so only a stalled result holds back the input.
// Counter and phase update in the cycle an event leaves the event register.
// Reset (rst_ni low, asynchronous): phase idle, count 120, step 5,
// upper limit 300, lower limit 40, both channel stages empty.
// ----------------------------------------------------------------------------
// Quadrature edge decoder counter
// Seven-phase quadrature decoder driving a bounded, saturating up/down
// counter, with APB-style access to step size and limits.
// ----------------------------------------------------------------------------
`include "quadrature_edge_decoder_counter_defines.svh"

module quadrature_edge_decoder_counter #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qedc_evt_if.sink    evt_i,
  qedc_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qedc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  // Configuration registers
  logic [7:0]  step_q;
  logic [15:0] upper_q;
  logic [15:0] lower_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_SIZE_RST;
      upper_q <= UPPER_LIMIT_RST;
      lower_q <= LOWER_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_STEP_SIZE:   step_q  <= pwdata[7:0];
        REG_UPPER_LIMIT: upper_q <= pwdata[15:0];
        REG_LOWER_LIMIT: lower_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STEP_SIZE:   prdata = {24'd0, step_q};
      REG_UPPER_LIMIT: prdata = {16'd0, upper_q};
      REG_LOWER_LIMIT: prdata = {16'd0, lower_q};
      default:         prdata = '0;
    endcase
  end

  // Event register
  logic s1_valid_q;
  evt_t s1_q;
  logic res_valid_q;
  res_t res_q;
  logic advance;
  logic s1_fire;

  assign advance     = !res_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && advance;
  assign evt_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      s1_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      s1_q <= evt_i.data;
    end
  end

  // Decoder and counter
  logic [2:0]             phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [1:0]             edge_code;
  logic [1:0]             move_raw;
  logic [1:0]             moved;
  logic                   inc_ok, dec_ok;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] step_ext;
  logic [COUNT_WIDTH-1:0] inc_val, dec_val;
  logic [CMP_W-1:0]       count_wide;

  assign edge_code  = {s1_q.edge_rising, s1_q.channel};
  assign move_raw   = edge_move(phase_q, edge_code);
  assign count_wide = CMP_W'(count_q);
  assign inc_ok     = count_wide < CMP_W'(upper_q);
  assign dec_ok     = count_wide > CMP_W'(lower_q);
  assign step_ext   = COUNT_WIDTH'(step_q);
  assign sum        = (COUNT_WIDTH+1)'(count_q) + (COUNT_WIDTH+1)'(step_q);
  // saturate at both ends of the counter range
  assign inc_val    = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
  assign dec_val    = (count_q < step_ext) ? '0 : count_q - step_ext;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    moved   = MOVE_NONE;
    if (s1_q.opcode == OP_LOAD) begin
      count_d = COUNT_WIDTH'(s1_q.new_count);
    end else begin
      phase_d = next_phase(phase_q, edge_code);
      if (move_raw == MOVE_INC && inc_ok) begin
        count_d = inc_val;
        moved   = MOVE_INC;
      end else if (move_raw == MOVE_DEC && dec_ok) begin
        count_d = dec_val;
        moved   = MOVE_DEC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= COUNT_WIDTH'(COUNT_RST);
    end else if (s1_fire) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q.count <= 16'(CMP_W'(count_d));
      res_q.phase <= phase_d;
      res_q.moved <= moved;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  `QEDC_ASSERT_IMP(a_phase_used, 1'b1, phase_q != PH_SPARE, "decoder reached unused phase")
  `QEDC_ASSERT_IMP(a_move_idle, res_valid_q && res_q.moved != MOVE_NONE,
    res_q.phase == PH_IDLE, "count moved without returning to idle")
  `QEDC_ASSERT_NXT(a_load_phase, s1_fire && s1_q.opcode == OP_LOAD, $stable(phase_q),
    "load changed decoder phase")
  `QEDC_ASSERT_NXT(a_stall_hold, !advance, $stable(count_q) && $stable(phase_q),
    "state changed while result stalled")

endmodule
